// ----- rtl/ppmd_pkg.sv -----
// Shared constants for the point to polyline minimum distance block.
package ppmd_pkg;

    // Default coordinate width and fraction bits of the signed inputs
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Fraction bits of the projection parameter t (unsigned Q1.16, 1.0 = 2^16)
    localparam int T_BITS = 16;

    // Width of the squared distance and of the emitted distance
    localparam int SQ_WIDTH   = 32;
    localparam int DIST_WIDTH = 16;

endpackage

// ----- rtl/ppmd_front.sv -----
// Front end: takes input beats and forms the segment and point difference vectors.
module ppmd_front #(
    parameter int COORD_WIDTH = ppmd_pkg::COORD_WIDTH_DEF,
    parameter int ENTRY_WIDTH = 4 * (COORD_WIDTH + 1) + 1
) (
    input  logic                          push,
    input  logic                          queue_full,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic signed [COORD_WIDTH-1:0] seg_start_x,
    input  logic signed [COORD_WIDTH-1:0] seg_start_z,
    input  logic signed [COORD_WIDTH-1:0] seg_end_x,
    input  logic signed [COORD_WIDTH-1:0] seg_end_z,
    input  logic                          last_segment,
    output logic                          wr_en,
    output logic [ENTRY_WIDTH-1:0]        wr_data
);

    localparam int DW = COORD_WIDTH + 1;

    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vz;
    logic signed [DW-1:0] wx;
    logic signed [DW-1:0] wz;

    // Form exact differences: v = end - start, w = point - start
    always_comb
    begin
        vx = DW'(seg_end_x) - DW'(seg_start_x);
        vz = DW'(seg_end_z) - DW'(seg_start_z);
        wx = DW'(point_x) - DW'(seg_start_x);
        wz = DW'(point_z) - DW'(seg_start_z);
    end

    // Hand the beat to the queue when there is room
    assign wr_en   = push && !queue_full;
    assign wr_data = {last_segment, wz, wx, vz, vx};

endmodule

// ----- rtl/ppmd_fifo.sv -----
// Small queue between the front and back ends, with registered read data.
module ppmd_fifo #(
    parameter int WIDTH = 69,
    parameter int DEPTH = ppmd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = rd_data_reg;

    // Write the storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Read the oldest entry into the output register
    always_ff @(posedge clk)
    begin
        if (do_rd)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/ppmd_back.sv -----
// Back end: projection, division, running minimum and square root sequencer.
module ppmd_back #(
    parameter int COORD_WIDTH = ppmd_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ppmd_pkg::FRAC_BITS_DEF,
    parameter int ENTRY_WIDTH = 4 * (COORD_WIDTH + 1) + 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 queue_empty,
    output logic                                 rd_en,
    input  logic [ENTRY_WIDTH-1:0]               rd_data,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [ppmd_pkg::DIST_WIDTH-1:0]      min_distance
);

    localparam int DW   = COORD_WIDTH + 1;
    localparam int DXW  = COORD_WIDTH + 3;
    localparam int TW   = ppmd_pkg::T_BITS + 1;
    localparam int MW   = (DXW > TW + 1) ? DXW : TW + 1;
    localparam int PW   = 2 * MW;
    localparam int SW   = PW + 1;
    localparam int SQW  = ppmd_pkg::SQ_WIDTH;
    localparam int CNTW = $clog2(ppmd_pkg::T_BITS);
    localparam logic [SW-1:0] EPS =
        SW'((64'd1 << (2 * FRAC_BITS)) / 64'd10000);
    localparam logic signed [PW-1:0] HALF = PW'(1) << (ppmd_pkg::T_BITS - 1);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_LOAD   = 14'b00000000000010,
        ST_LEN_A  = 14'b00000000000100,
        ST_LEN_B  = 14'b00000000001000,
        ST_DOT_A  = 14'b00000000010000,
        ST_DOT_B  = 14'b00000000100000,
        ST_CLASS  = 14'b00000001000000,
        ST_DIVIDE = 14'b00000010000000,
        ST_PROJ_X = 14'b00000100000000,
        ST_PROJ_Z = 14'b00001000000000,
        ST_SQ_A   = 14'b00010000000000,
        ST_SQ_B   = 14'b00100000000000,
        ST_ROOT   = 14'b01000000000000,
        ST_EMIT   = 14'b10000000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic signed [DW-1:0]    vx_reg, vz_reg, wx_reg, wz_reg;
    logic                    last_reg;
    logic signed [SW-1:0]    acc_reg;
    logic [SW-1:0]           len_reg;
    logic signed [SW-1:0]    dot_reg;
    logic [SW-1:0]           rem_reg;
    logic [TW-1:0]           t_reg;
    logic signed [DXW-1:0]   dx_reg, dz_reg;
    logic [SQW-1:0]          best_reg;
    logic [SQW-1:0]          root_v_reg, root_reg, root_bit_reg;
    logic [CNTW-1:0]         cnt_reg;
    logic                    out_valid_reg;
    logic [ppmd_pkg::DIST_WIDTH-1:0] out_reg;

    logic signed [MW-1:0]    op_a, op_b;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    rnd;
    logic signed [DXW-1:0]   proj_diff;
    logic signed [SW-1:0]    sq_sum;
    logic [SQW-1:0]          sq_sat;
    logic [SQW-1:0]          best_new;
    logic [SW-1:0]           rem_shift;
    logic                    div_bit;
    logic [SQW:0]            root_try;
    logic                    root_fit;
    logic                    out_free;
    logic                    cnt_done;

    assign out_free     = !out_valid_reg || pop;
    assign empty        = !out_valid_reg;
    assign min_distance = out_reg;
    assign rd_en        = (state_reg == ST_IDLE) && !queue_empty;
    assign cnt_done     = (cnt_reg == CNTW'(ppmd_pkg::T_BITS - 1));

    // Select the operands of the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_LEN_A:  begin op_a = MW'(vx_reg); op_b = MW'(vx_reg); end
            ST_LEN_B:  begin op_a = MW'(vz_reg); op_b = MW'(vz_reg); end
            ST_DOT_A:  begin op_a = MW'(wx_reg); op_b = MW'(vx_reg); end
            ST_DOT_B:  begin op_a = MW'(wz_reg); op_b = MW'(vz_reg); end
            ST_PROJ_X: begin op_a = MW'(vx_reg); op_b = MW'(signed'({1'b0, t_reg})); end
            ST_PROJ_Z: begin op_a = MW'(vz_reg); op_b = MW'(signed'({1'b0, t_reg})); end
            ST_SQ_A:   begin op_a = MW'(dx_reg); op_b = MW'(dx_reg); end
            ST_SQ_B:   begin op_a = MW'(dz_reg); op_b = MW'(dz_reg); end
            default:   begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod = op_a * op_b;

    // Round the scaled projection half up and subtract it from w
    always_comb
    begin
        rnd = (prod + HALF) >>> ppmd_pkg::T_BITS;
        if (state_reg == ST_PROJ_X)
        begin
            proj_diff = DXW'(PW'(wx_reg) - rnd);
        end
        else
        begin
            proj_diff = DXW'(PW'(wz_reg) - rnd);
        end
    end

    // Sum the squared distance, saturate and fold into the minimum
    always_comb
    begin
        sq_sum   = acc_reg + SW'(prod);
        sq_sat   = (|sq_sum[SW-1:SQW]) ? '1 : sq_sum[SQW-1:0];
        best_new = (sq_sat < best_reg) ? sq_sat : best_reg;
    end

    // One restoring division step and one square root step
    always_comb
    begin
        rem_shift = rem_reg << 1;
        div_bit   = (rem_shift >= len_reg);
        root_try  = {1'b0, root_reg} + {1'b0, root_bit_reg};
        root_fit  = ({1'b0, root_v_reg} >= root_try);
    end

    // Step the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (!queue_empty) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_LEN_A;
            ST_LEN_A:  state_next = ST_LEN_B;
            ST_LEN_B:  state_next = ST_DOT_A;
            ST_DOT_A:  state_next = ST_DOT_B;
            ST_DOT_B:  state_next = ST_CLASS;
            ST_CLASS:
            begin
                if (len_reg <= EPS || dot_reg <= 0 || dot_reg >= signed'(len_reg))
                begin
                    state_next = ST_PROJ_X;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: if (cnt_done) state_next = ST_PROJ_X;
            ST_PROJ_X: state_next = ST_PROJ_Z;
            ST_PROJ_Z: state_next = ST_SQ_A;
            ST_SQ_A:   state_next = ST_SQ_B;
            ST_SQ_B:   state_next = last_reg ? ST_ROOT : ST_IDLE;
            ST_ROOT:   if (cnt_done) state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            best_reg      <= '1;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_SQ_B)
            begin
                best_reg <= last_reg ? '1 : best_new;
            end
            if (state_reg == ST_DIVIDE || state_reg == ST_ROOT)
            begin
                cnt_reg <= cnt_done ? '0 : cnt_reg + 1'b1;
            end
        end
    end

    // Advance the datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LOAD:
            begin
                {last_reg, wz_reg, wx_reg, vz_reg, vx_reg} <= rd_data;
            end
            ST_LEN_A:  acc_reg <= SW'(prod);
            ST_LEN_B:  len_reg <= sq_sum;
            ST_DOT_A:  acc_reg <= SW'(prod);
            ST_DOT_B:  dot_reg <= sq_sum;
            ST_CLASS:
            begin
                rem_reg <= dot_reg;
                if (len_reg <= EPS || dot_reg <= 0)
                begin
                    t_reg <= '0;
                end
                else if (dot_reg >= signed'(len_reg))
                begin
                    t_reg <= TW'(1) << ppmd_pkg::T_BITS;
                end
                else
                begin
                    t_reg <= '0;
                end
            end
            ST_DIVIDE:
            begin
                rem_reg <= div_bit ? rem_shift - len_reg : rem_shift;
                t_reg   <= {t_reg[TW-2:0], div_bit};
            end
            ST_PROJ_X: dx_reg <= proj_diff;
            ST_PROJ_Z: dz_reg <= proj_diff;
            ST_SQ_A:   acc_reg <= SW'(prod);
            ST_SQ_B:
            begin
                root_v_reg   <= best_new;
                root_reg     <= '0;
                root_bit_reg <= SQW'(1) << (SQW - 2);
            end
            ST_ROOT:
            begin
                if (root_fit)
                begin
                    root_v_reg <= SQW'({1'b0, root_v_reg} - root_try);
                    root_reg   <= (root_reg >> 1) + root_bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                root_bit_reg <= root_bit_reg >> 2;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_reg <= root_reg[ppmd_pkg::DIST_WIDTH-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- rtl/point_polyline_min_distance.sv -----
// Top level of the point to polyline minimum distance block.
// Each pushed beat carries a query point and one segment; the block keeps the
// smallest squared distance over a run of segments and, on the beat marked
// last_segment, offers the floor of its square root (unsigned Q8.8, saturated)
// as one result beat. The back-end sequencer works on one segment at a time with
// its single shared multiplier and a restoring divider for the projection
// parameter (skipped when no division is needed); the last segment adds a
// bit-serial square root and the hand-off to the output register. A small
// queue lets several beats be pushed while the sequencer works, and a finished
// result waits in an output register without stopping the next segment.
module point_polyline_min_distance #(
    parameter int COORD_WIDTH = ppmd_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ppmd_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = ppmd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [COORD_WIDTH-1:0]      point_x,
    input  logic signed [COORD_WIDTH-1:0]      point_z,
    input  logic signed [COORD_WIDTH-1:0]      seg_start_x,
    input  logic signed [COORD_WIDTH-1:0]      seg_start_z,
    input  logic signed [COORD_WIDTH-1:0]      seg_end_x,
    input  logic signed [COORD_WIDTH-1:0]      seg_end_z,
    input  logic                               last_segment,
    output logic                               empty,
    input  logic                               pop,
    output logic [ppmd_pkg::DIST_WIDTH-1:0]    min_distance
);

    localparam int EW = 4 * (COORD_WIDTH + 1) + 1;

    logic          wr_en;
    logic [EW-1:0] wr_data;
    logic          rd_en;
    logic [EW-1:0] rd_data;
    logic          queue_empty;

    ppmd_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .ENTRY_WIDTH (EW)
    ) u_front (
        .push         (push),
        .queue_full   (full),
        .point_x      (point_x),
        .point_z      (point_z),
        .seg_start_x  (seg_start_x),
        .seg_start_z  (seg_start_z),
        .seg_end_x    (seg_end_x),
        .seg_end_z    (seg_end_z),
        .last_segment (last_segment),
        .wr_en        (wr_en),
        .wr_data      (wr_data)
    );

    ppmd_fifo #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_data (rd_data),
        .full    (full),
        .empty   (queue_empty)
    );

    ppmd_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .ENTRY_WIDTH (EW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .rd_en        (rd_en),
        .rd_data      (rd_data),
        .empty        (empty),
        .pop          (pop),
        .min_distance (min_distance)
    );

endmodule

// ----- tb/tb.sv -----
// Testbench for the point to polyline minimum distance block.
`timescale 1ns / 100ps

// Scoreboard: predicts the minimum distance per polyline and checks result beats.
class distance_scoreboard;
    logic [31:0] best_sq;
    logic [15:0] expected_q[$];
    int          mismatches;
    int          results_seen;
    int          segments_seen;
    int          short_segments;
    int          clamped_low;
    int          clamped_high;
    int          saturated;

    function void clear_min();
        best_sq = 32'hFFFF_FFFF;
    endfunction

    // Round v*t / 2^16 half toward plus infinity.
    function longint scale_round(longint p);
        longint q;
        q = p + 64'sd32768;
        return q >>> 16;
    endfunction

    function logic [15:0] int_sqrt(logic [31:0] v);
        logic [31:0] root;
        logic [31:0] bitv;
        root = 0;
        bitv = 32'h4000_0000;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return (root > 32'hFFFF) ? 16'hFFFF : root[15:0];
    endfunction

    // Note an accepted segment beat and fold it into the running minimum.
    function void note_segment(logic signed [15:0] px, logic signed [15:0] pz,
                               logic signed [15:0] ax, logic signed [15:0] az,
                               logic signed [15:0] bx, logic signed [15:0] bz,
                               logic last);
        longint vx, vz, wx, wz, len, dot, t, qx, qz, dx, dz, sq;
        vx = longint'(bx) - longint'(ax);
        vz = longint'(bz) - longint'(az);
        wx = longint'(px) - longint'(ax);
        wz = longint'(pz) - longint'(az);
        len = vx * vx + vz * vz;
        dot = wx * vx + wz * vz;
        segments_seen++;
        if (len <= 6)
        begin
            t = 0;
            short_segments++;
        end
        else if (dot <= 0)
        begin
            t = 0;
            clamped_low++;
        end
        else if (dot >= len)
        begin
            t = 65536;
            clamped_high++;
        end
        else
        begin
            t = (dot * 65536) / len;
        end
        qx = longint'(ax) + scale_round(vx * t);
        qz = longint'(az) + scale_round(vz * t);
        dx = longint'(px) - qx;
        dz = longint'(pz) - qz;
        sq = dx * dx + dz * dz;
        if (sq > 64'h0000_0000_FFFF_FFFF)
            sq = 64'h0000_0000_FFFF_FFFF;
        if (sq[31:0] < best_sq)
            best_sq = sq[31:0];
        if (last)
        begin
            if (best_sq == 32'hFFFF_FFFF)
                saturated++;
            expected_q.push_back(int_sqrt(best_sq));
            clear_min();
        end
    endfunction

    // Check one result beat against the oldest expected distance.
    function void check_distance(logic [15:0] actual);
        logic [15:0] want;
        results_seen++;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result beat min_distance=%0d", actual);
            return;
        end
        want = expected_q.pop_front();
        if (actual !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: min_distance expected %0d actual %0d", want, actual);
        end
    endfunction
endclass

module tb;

    localparam int RANDOM_ITEMS = 1750;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic signed [15:0] point_x;
    logic signed [15:0] point_z;
    logic signed [15:0] seg_start_x;
    logic signed [15:0] seg_start_z;
    logic signed [15:0] seg_end_x;
    logic signed [15:0] seg_end_z;
    logic        last_segment;
    logic        empty;
    logic        pop;
    logic [15:0] min_distance;

    distance_scoreboard sb;
    longint cycle_count;
    bit     calm_phase;

    point_polyline_min_distance i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .point_x      (point_x),
        .point_z      (point_z),
        .seg_start_x  (seg_start_x),
        .seg_start_z  (seg_start_z),
        .seg_end_x    (seg_end_x),
        .seg_end_z    (seg_end_z),
        .last_segment (last_segment),
        .empty        (empty),
        .pop          (pop),
        .min_distance (min_distance)
    );

    // Generate the clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles and stop on timeout.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("ERROR: timeout after %0d cycles", cycle_count);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Push one segment beat; hold it until accepted, optionally idle first.
    // Push stays high after the beat until the next call or the caller drops it.
    task automatic send_segment(logic [15:0] px, logic [15:0] pz, logic [15:0] ax,
                                logic [15:0] az, logic [15:0] bx, logic [15:0] bz,
                                logic last);
        int gap;
        if (!calm_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push         <= 1'b1;
        point_x      <= px;
        point_z      <= pz;
        seg_start_x  <= ax;
        seg_start_z  <= az;
        seg_end_x    <= bx;
        seg_end_z    <= bz;
        last_segment <= last;
        do
            @(posedge clk);
        while (full);
        sb.note_segment(px, pz, ax, az, bx, bz, last);
        @(negedge clk);
    endtask

    // Random coordinate: mostly a local cluster, sometimes full range.
    function automatic logic [15:0] rand_coord(logic [15:0] center);
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom_range(0, 65535));
        return center + 16'($signed($urandom_range(0, 4095)) - 2048);
    endfunction

    // Send a polyline of random segments around a random point.
    task automatic send_polyline();
        int n;
        logic [15:0] px, pz, cx, cz, ax, az, bx, bz;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        px = 16'($urandom_range(0, 65535));
        pz = 16'($urandom_range(0, 65535));
        cx = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : px;
        cz = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : pz;
        ax = rand_coord(cx);
        az = rand_coord(cz);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                bx = ax + 16'($urandom_range(0, 2));
                bz = az;
            end
            else
            begin
                bx = rand_coord(cx);
                bz = rand_coord(cz);
            end
            send_segment(px, pz, ax, az, bx, bz, i == n - 1);
            ax = ($urandom_range(0, 4) == 0) ? rand_coord(cx) : bx;
            az = ($urandom_range(0, 4) == 0) ? rand_coord(cz) : bz;
        end
    endtask

    // Pop result beats with random stall bursts and check each one.
    initial
    begin
        int stall;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm_phase && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 15);
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            if (!empty && pop)
                sb.check_distance(min_distance);
        end
    end

    // Main sequence: reset, directed cases, random polylines, drain.
    initial
    begin
        int sent;
        int wait_cycles;
        sb = new();
        sb.clear_min();
        calm_phase   = 1'b0;
        push         <= 1'b0;
        point_x      <= '0;
        point_z      <= '0;
        seg_start_x  <= '0;
        seg_start_z  <= '0;
        seg_end_x    <= '0;
        seg_end_z    <= '0;
        last_segment <= 1'b0;
        rst_n        <= 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, zero-length and short segments, clamps, saturation.
        send_segment(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        send_segment(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8001, 1'b1);
        send_segment(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_segment(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0002, 16'h0001, 1'b1);
        send_segment(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0002, 16'h0002, 1'b1);
        send_segment(16'hFF00, 16'h0100, 16'h0000, 16'h0000, 16'h0400, 16'h0000, 1'b0);
        send_segment(16'h0800, 16'h0100, 16'h0000, 16'h0000, 16'h0400, 16'h0000, 1'b0);
        send_segment(16'h0200, 16'h0100, 16'h0000, 16'h0000, 16'h0400, 16'h0000, 1'b1);
        send_segment(16'h0033, 16'hFFCD, 16'hFF80, 16'h0080, 16'h0080, 16'hFF80, 1'b1);
        send_segment(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0);
        send_segment(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
        send_segment(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001, 1'b1);
        send_segment(16'h0001, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0001, 1'b1);
        push <= 1'b0;

        // Let everything drain so the sender sits idle with nothing pending.
        while (sb.expected_q.size() != 0)
            @(negedge clk);

        // Random polylines; last part without idling.
        sent = sb.segments_seen;
        while (sb.segments_seen - sent < RANDOM_ITEMS)
        begin
            if (sb.segments_seen - sent > RANDOM_ITEMS * 4 / 5)
                calm_phase = 1'b1;
            send_polyline();
        end
        push <= 1'b0;

        // Drain and let the pipeline settle.
        wait_cycles = 0;
        while (sb.expected_q.size() != 0 && wait_cycles < 20000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (100) @(negedge clk);

        $display("Covered %0d segments, %0d distances: %0d short, %0d before start,",
                 sb.segments_seen, sb.results_seen, sb.short_segments, sb.clamped_low);
        $display("  %0d beyond end, %0d saturated; %0d mismatches, %0d pending.",
                 sb.clamped_high, sb.saturated, sb.mismatches, sb.expected_q.size());
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
